// ===== rtl/core/eas_pkg.sv =====
// ----------------------------------------------------------------------------
// eas_pkg: shared types and constants of the encoder angle and speed estimator
// Field widths, register codes, reset values and the reciprocal scale used
// by the modulo stage.
// ----------------------------------------------------------------------------
package eas_pkg;

  localparam int unsigned CNT_W     = 16;
  localparam int unsigned ANGLE_W   = 16;
  localparam int unsigned WEIGHT_W  = 11;
  localparam int unsigned COEFF_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DW    = 16;

  localparam int unsigned DEF_COUNTS_PER_ELEC_REV = 1000;
  localparam int unsigned DEF_ANGLE_SHIFT         = 6;

  // remainder before correction stays below twice the largest divisor
  localparam int unsigned REM_W       = 11;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

  localparam logic [ANGLE_W-1:0]  RST_ANGLE_OFFSET = 16'd22180;
  localparam logic [WEIGHT_W-1:0] RST_OLD_WEIGHT   = 11'd355;
  localparam logic [WEIGHT_W-1:0] RST_NEW_WEIGHT   = 11'd669;
  localparam logic [COEFF_W-1:0]  RST_RPM_COEFF    = 16'd7500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_OFFSET = 2'd0,
    REG_OLD_WEIGHT   = 2'd1,
    REG_NEW_WEIGHT   = 2'd2,
    REG_RPM_COEFF    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] old_weight;
    logic [WEIGHT_W-1:0] new_weight;
    logic [COEFF_W-1:0]  rpm_coeff;
  } speed_cfg_t;

  typedef struct packed {
    logic                kind;
    logic [ANGLE_W-1:0]  angle;
  } angle_item_t;

endpackage

// ===== rtl/core/encoder_angle_speed_estimator.sv =====
// ----------------------------------------------------------------------------
// encoder_angle_speed_estimator: incremental encoder angle and speed estimator
// Input channel (in_valid/in_ready) carries kind and encoder_count; the
// result channel (out_valid/out_ready) carries elec_angle, angle_step,
// speed_filtered and rpm, one result per input transfer, in order.
// Kind 0 updates the angle only; kind 1 also updates step, filter and rpm.
// The input passes three angle stages and then one speed stage that holds
// the result register.
// Throughput: one item per clock while the result side takes results; the
// filter feedback closes in the speed stage, with three 16x11/16x16 multipliers.
// Each stage fills when its successor frees, so items keep entering while a
// result waits; with all four stages full, in_ready follows out_ready.
// Reset (rst_n, synchronous) empties the pipeline, zeroes the speed state and
// loads the register defaults. Write the cfg_ port only while idle.
// ----------------------------------------------------------------------------
module encoder_angle_speed_estimator
  import eas_pkg::*;
#(
  parameter int unsigned COUNTS_PER_ELEC_REV = DEF_COUNTS_PER_ELEC_REV,
  parameter int unsigned ANGLE_SHIFT         = DEF_ANGLE_SHIFT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [CNT_W-1:0]     in_encoder_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ANGLE_W-1:0]   out_elec_angle,
  output logic [ANGLE_W-1:0]   out_angle_step,
  output logic [ANGLE_W-1:0]   out_speed_filtered,
  output logic [ANGLE_W-1:0]   out_rpm,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata
);

  logic [ANGLE_W-1:0]  angle_offset_r;
  logic [WEIGHT_W-1:0] old_weight_r;
  logic [WEIGHT_W-1:0] new_weight_r;
  logic [COEFF_W-1:0]  rpm_coeff_r;

  speed_cfg_t  speed_cfg;
  logic        mid_valid, mid_ready;
  angle_item_t mid_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_offset_r <= RST_ANGLE_OFFSET;
      old_weight_r   <= RST_OLD_WEIGHT;
      new_weight_r   <= RST_NEW_WEIGHT;
      rpm_coeff_r    <= RST_RPM_COEFF;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_ANGLE_OFFSET: angle_offset_r <= cfg_wdata[ANGLE_W-1:0];
        REG_OLD_WEIGHT:   old_weight_r   <= cfg_wdata[WEIGHT_W-1:0];
        REG_NEW_WEIGHT:   new_weight_r   <= cfg_wdata[WEIGHT_W-1:0];
        REG_RPM_COEFF:    rpm_coeff_r    <= cfg_wdata[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  assign speed_cfg.old_weight = old_weight_r;
  assign speed_cfg.new_weight = new_weight_r;
  assign speed_cfg.rpm_coeff  = rpm_coeff_r;

  eas_angle #(
    .COUNTS_PER_ELEC_REV (COUNTS_PER_ELEC_REV),
    .ANGLE_SHIFT         (ANGLE_SHIFT)
  ) u_angle (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_count     (in_encoder_count),
    .angle_offset (angle_offset_r),
    .dn_valid     (mid_valid),
    .dn_ready     (mid_ready),
    .dn_item      (mid_item)
  );

  eas_speed u_speed (
    .clk                (clk),
    .rst_n              (rst_n),
    .up_valid           (mid_valid),
    .up_ready           (mid_ready),
    .up_item            (mid_item),
    .cfg                (speed_cfg),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_elec_angle     (out_elec_angle),
    .out_angle_step     (out_angle_step),
    .out_speed_filtered (out_speed_filtered),
    .out_rpm            (out_rpm)
  );

endmodule

// ===== rtl/core/eas_angle.sv =====
// ----------------------------------------------------------------------------
// eas_angle: corrected electrical angle pipeline
// Reduces the raw count modulo the counts per electrical turn by reciprocal
// multiplication, scales it and adds the angle offset. Three stages.
// ----------------------------------------------------------------------------
module eas_angle
  import eas_pkg::*;
#(
  parameter int unsigned COUNTS_PER_ELEC_REV = DEF_COUNTS_PER_ELEC_REV,
  parameter int unsigned ANGLE_SHIFT         = DEF_ANGLE_SHIFT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_kind,
  input  logic [CNT_W-1:0]   in_count,
  input  logic [ANGLE_W-1:0] angle_offset,
  output logic               dn_valid,
  input  logic               dn_ready,
  output angle_item_t        dn_item
);

  localparam int unsigned RECIP = (2 ** RECIP_SHIFT) / COUNTS_PER_ELEC_REV;
  localparam int unsigned PROD_W = CNT_W + RECIP_W;

  logic               s1_valid_r, s2_valid_r, s3_valid_r;
  logic               s1_kind_r, s2_kind_r;
  logic [CNT_W-1:0]   s1_count_r, s2_count_r;
  logic [CNT_W-1:0]   s2_quot_r;
  angle_item_t        s3_item_r;

  logic               s3_ready, s2_ready;
  logic [PROD_W-1:0]  quot_prod;
  logic [CNT_W-1:0]   quot_nxt;
  logic [RECIP_W-1:0] back_prod;
  logic [CNT_W-1:0]   diff;
  logic [REM_W-1:0]   rem_raw, rem;
  logic [ANGLE_W-1:0] scaled;
  angle_item_t        s3_item_nxt;

  assign s3_ready = !s3_valid_r || dn_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign in_ready = !s1_valid_r || s2_ready;

  always_comb begin
    quot_prod = {{RECIP_W{1'b0}}, s1_count_r} * {{CNT_W{1'b0}}, RECIP_W'(RECIP)};
    quot_nxt  = quot_prod[RECIP_SHIFT +: CNT_W];
  end

  always_comb begin
    back_prod = {{(RECIP_W-CNT_W){1'b0}}, s2_quot_r} * RECIP_W'(COUNTS_PER_ELEC_REV);
    diff      = s2_count_r - back_prod[CNT_W-1:0];
    rem_raw   = diff[REM_W-1:0];
    rem       = (rem_raw >= REM_W'(COUNTS_PER_ELEC_REV)) ?
                rem_raw - REM_W'(COUNTS_PER_ELEC_REV) : rem_raw;
    scaled    = ANGLE_W'({{(ANGLE_W-REM_W){1'b0}}, rem} << ANGLE_SHIFT);
    s3_item_nxt.kind  = s2_kind_r;
    s3_item_nxt.angle = scaled + angle_offset;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_kind_r  <= in_kind;
      s1_count_r <= in_count;
    end
    if (s2_ready && s1_valid_r) begin
      s2_kind_r  <= s1_kind_r;
      s2_count_r <= s1_count_r;
      s2_quot_r  <= quot_nxt;
    end
    if (s3_ready && s2_valid_r) begin
      s3_item_r <= s3_item_nxt;
    end
  end

  assign dn_valid = s3_valid_r;
  assign dn_item  = s3_item_r;

  a_in_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s2_valid_r && s3_valid_r))
    else $error("input stalled with a free stage");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(s1_count_r)))
    else $error("first stage lost a held item");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (rem < REM_W'(COUNTS_PER_ELEC_REV)))
    else $error("remainder not reduced");

endmodule

// ===== rtl/core/eas_speed.sv =====
// ----------------------------------------------------------------------------
// eas_speed: angle step, speed filter and rpm stage with result register
// Closes the filter feedback within the stage and holds the result until the
// output transfer.
// ----------------------------------------------------------------------------
module eas_speed
  import eas_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  angle_item_t        up_item,
  input  speed_cfg_t         cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ANGLE_W-1:0] out_elec_angle,
  output logic [ANGLE_W-1:0] out_angle_step,
  output logic [ANGLE_W-1:0] out_speed_filtered,
  output logic [ANGLE_W-1:0] out_rpm
);

  localparam int unsigned WPROD_W = WEIGHT_W + ANGLE_W;
  localparam int unsigned TERM_W  = WPROD_W - 10;
  localparam int unsigned SUM_W   = TERM_W + 1;

  logic               out_valid_r;
  logic [ANGLE_W-1:0] elec_angle_r;
  logic [ANGLE_W-1:0] prev_angle_r, prev_angle_nxt;
  logic [ANGLE_W-1:0] filter_acc_r, filter_acc_nxt;
  logic [ANGLE_W-1:0] last_step_r, last_step_nxt;
  logic [ANGLE_W-1:0] last_rpm_r, last_rpm_nxt;

  logic                      load;
  logic [ANGLE_W-1:0]        step;
  logic [WPROD_W-1:0]        old_prod, new_prod;
  logic [SUM_W-1:0]          filt_sum;
  logic [ANGLE_W+COEFF_W-1:0] rpm_prod;

  assign up_ready = !out_valid_r || out_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    step     = prev_angle_r - up_item.angle;
    old_prod = {{ANGLE_W{1'b0}}, cfg.old_weight} * {{WEIGHT_W{1'b0}}, filter_acc_r};
    new_prod = {{ANGLE_W{1'b0}}, cfg.new_weight} * {{WEIGHT_W{1'b0}}, step};
    filt_sum = {1'b0, old_prod[WPROD_W-1:10]} + {1'b0, new_prod[WPROD_W-1:10]};
    rpm_prod = {{COEFF_W{1'b0}}, step} * {{ANGLE_W{1'b0}}, cfg.rpm_coeff};

    prev_angle_nxt = prev_angle_r;
    filter_acc_nxt = filter_acc_r;
    last_step_nxt  = last_step_r;
    last_rpm_nxt   = last_rpm_r;
    if (load && up_item.kind) begin
      prev_angle_nxt = up_item.angle;
      filter_acc_nxt = (filt_sum > SUM_W'(16'hFFFF)) ? 16'hFFFF : filt_sum[ANGLE_W-1:0];
      last_step_nxt  = step;
      last_rpm_nxt   = rpm_prod[COEFF_W +: ANGLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      prev_angle_r <= '0;
      filter_acc_r <= '0;
      last_step_r  <= '0;
      last_rpm_r   <= '0;
    end else begin
      if (up_ready) out_valid_r <= up_valid;
      prev_angle_r <= prev_angle_nxt;
      filter_acc_r <= filter_acc_nxt;
      last_step_r  <= last_step_nxt;
      last_rpm_r   <= last_rpm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) elec_angle_r <= up_item.angle;
  end

  assign out_valid          = out_valid_r;
  assign out_elec_angle     = elec_angle_r;
  assign out_angle_step     = last_step_r;
  assign out_speed_filtered = filter_acc_r;
  assign out_rpm            = last_rpm_r;

  a_angle_item_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !up_item.kind) |=>
      ($stable(prev_angle_r) && $stable(filter_acc_r) && $stable(last_rpm_r)))
    else $error("angle item changed speed state");

  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=>
      (out_valid_r && $stable(elec_angle_r) && $stable(filter_acc_r)))
    else $error("held result changed");

  a_speed_stores_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (load && up_item.kind) |=> (prev_angle_r == elec_angle_r))
    else $error("speed item did not store angle");

endmodule

// ===== tb/angle_speed_checker.sv =====
// ----------------------------------------------------------------------------
// angle_speed_checker: scoreboard for the encoder angle and speed estimator
// Follows register writes and input transfers and works out the expected
// angle, step, filtered speed and rpm of every item from its own copy of the
// registers and speed state. Compares every result transfer, field by field,
// with the oldest expected estimate and counts the mismatches.
// ----------------------------------------------------------------------------
module angle_speed_checker
  import eas_pkg::*;
#(
  parameter int unsigned COUNTS_PER_ELEC_REV = DEF_COUNTS_PER_ELEC_REV,
  parameter int unsigned ANGLE_SHIFT         = DEF_ANGLE_SHIFT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_kind,
  input  logic [CNT_W-1:0]     in_encoder_count,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [ANGLE_W-1:0]   out_elec_angle,
  input  logic [ANGLE_W-1:0]   out_angle_step,
  input  logic [ANGLE_W-1:0]   out_speed_filtered,
  input  logic [ANGLE_W-1:0]   out_rpm,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_wdata,
  output int unsigned          mismatches,
  output int unsigned          outstanding,
  output int unsigned          results_checked,
  output int unsigned          saturations
);

  typedef struct packed {
    logic [ANGLE_W-1:0] elec_angle;
    logic [ANGLE_W-1:0] angle_step;
    logic [ANGLE_W-1:0] speed_filtered;
    logic [ANGLE_W-1:0] rpm;
  } estimate_t;

  logic [ANGLE_W-1:0] offset_reg;
  speed_cfg_t         speed_cfg;
  logic [ANGLE_W-1:0] stored_angle;
  logic [ANGLE_W-1:0] filter_state;
  logic [ANGLE_W-1:0] held_step;
  logic [ANGLE_W-1:0] held_rpm;
  estimate_t          expected_estimates[$];
  int unsigned        err_count   = 0;
  int unsigned        match_count = 0;
  int unsigned        sat_count   = 0;
  int unsigned        queue_depth = 0;

  assign mismatches      = err_count;
  assign outstanding     = queue_depth;
  assign results_checked = match_count;
  assign saturations     = sat_count;

  function automatic estimate_t track_encoder(input logic kind,
                                              input logic [CNT_W-1:0] count);
    logic [31:0]        scaled;
    logic [31:0]        blend;
    logic [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0] step;
    estimate_t          est;
    scaled = (32'(count) % COUNTS_PER_ELEC_REV) << ANGLE_SHIFT;
    angle  = ANGLE_W'(scaled + 32'(offset_reg));
    if (kind) begin
      step  = stored_angle - angle;
      blend = ((32'(speed_cfg.old_weight) * 32'(filter_state)) >> 10)
            + ((32'(speed_cfg.new_weight) * 32'(step)) >> 10);
      if (blend > 32'hFFFF) begin
        blend = 32'hFFFF;
        sat_count++;
      end
      filter_state = ANGLE_W'(blend);
      held_step    = step;
      held_rpm     = ANGLE_W'((32'(step) * 32'(speed_cfg.rpm_coeff)) >> 16);
      stored_angle = angle;
    end
    est.elec_angle     = angle;
    est.angle_step     = held_step;
    est.speed_filtered = filter_state;
    est.rpm            = held_rpm;
    return est;
  endfunction

  task automatic check_field(input string label, input logic [ANGLE_W-1:0] want,
                             input logic [ANGLE_W-1:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t %s mismatch: expected %h actual %h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    estimate_t want;
    if (!rst_n) begin
      offset_reg           = RST_ANGLE_OFFSET;
      speed_cfg.old_weight = RST_OLD_WEIGHT;
      speed_cfg.new_weight = RST_NEW_WEIGHT;
      speed_cfg.rpm_coeff  = RST_RPM_COEFF;
      stored_angle         = '0;
      filter_state         = '0;
      held_step            = '0;
      held_rpm             = '0;
      expected_estimates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          REG_ANGLE_OFFSET: offset_reg           = cfg_wdata[ANGLE_W-1:0];
          REG_OLD_WEIGHT:   speed_cfg.old_weight = cfg_wdata[WEIGHT_W-1:0];
          REG_NEW_WEIGHT:   speed_cfg.new_weight = cfg_wdata[WEIGHT_W-1:0];
          REG_RPM_COEFF:    speed_cfg.rpm_coeff  = cfg_wdata[COEFF_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_estimates.size() == 0) begin
          err_count++;
          $display("%0t result transfer with nothing expected: expected none actual %h",
                   $time, {out_elec_angle, out_angle_step, out_speed_filtered,
                           out_rpm});
        end else begin
          want = expected_estimates.pop_front();
          check_field("elec_angle", want.elec_angle, out_elec_angle);
          check_field("angle_step", want.angle_step, out_angle_step);
          check_field("speed_filtered", want.speed_filtered, out_speed_filtered);
          check_field("rpm", want.rpm, out_rpm);
          match_count++;
        end
      end
      if (in_valid && in_ready)
        expected_estimates.push_back(track_encoder(in_kind, in_encoder_count));
    end
    queue_depth <= expected_estimates.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench top for the encoder angle and speed estimator
// Drives directed and random encoder samples through the valid/ready input
// with random gaps and result stalls, one long result hold-off, and several
// register settings including the extremes. The checker predicts and compares;
// this top makes the stimulus, runs the watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import eas_pkg::*;

  localparam int unsigned PIPE_DEPTH   = 4;
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned N_SETTINGS   = 6;
  localparam int unsigned CALM_ITEMS   = 100;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 60;

  logic               clk              = 1'b0;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_ready;
  logic               in_kind          = 1'b0;
  logic [CNT_W-1:0]   in_encoder_count = '0;
  logic               out_valid;
  logic               out_ready        = 1'b0;
  logic [ANGLE_W-1:0] out_elec_angle;
  logic [ANGLE_W-1:0] out_angle_step;
  logic [ANGLE_W-1:0] out_speed_filtered;
  logic [ANGLE_W-1:0] out_rpm;
  logic               cfg_we           = 1'b0;
  cfg_idx_t           cfg_index        = REG_ANGLE_OFFSET;
  logic [CFG_DW-1:0]  cfg_wdata        = '0;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_checked;
  int unsigned saturations;
  int unsigned items_sent     = 0;
  int unsigned speed_items    = 0;
  int unsigned settings_used  = 1;
  int unsigned quiet_cycles   = 0;
  bit          calm           = 1'b0;
  bit          hold_done      = 1'b0;
  logic [CNT_W-1:0] last_count = '0;

  always #10 clk = ~clk;

  encoder_angle_speed_estimator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_encoder_count   (in_encoder_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_elec_angle     (out_elec_angle),
    .out_angle_step     (out_angle_step),
    .out_speed_filtered (out_speed_filtered),
    .out_rpm            (out_rpm),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  angle_speed_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_encoder_count   (in_encoder_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_elec_angle     (out_elec_angle),
    .out_angle_step     (out_angle_step),
    .out_speed_filtered (out_speed_filtered),
    .out_rpm            (out_rpm),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .mismatches         (mismatches),
    .outstanding        (outstanding),
    .results_checked    (results_checked),
    .saturations        (saturations)
  );

  task automatic offer(input logic kind, input logic [CNT_W-1:0] count);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_encoder_count <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (kind)
      speed_items++;
    last_count = count;
  endtask

  task automatic offer_random;
    int unsigned      pick;
    logic [CNT_W-1:0] count;
    pick = $urandom_range(0, 9);
    if (pick < 5)
      count = last_count + CNT_W'($urandom_range(0, 80)) - CNT_W'(40);
    else if (pick < 8)
      count = CNT_W'($urandom);
    else
      count = CNT_W'(DEF_COUNTS_PER_ELEC_REV * $urandom_range(0, 65)
                     + ($urandom_range(0, 1) ? $urandom_range(0, 2)
                                             : $urandom_range(997, 999)));
    offer(1'($urandom_range(0, 1)), count);
  endtask

  // drain the pipeline before touching the registers
  task automatic settle;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic load_settings(input logic [CFG_DW-1:0] offset, input logic [CFG_DW-1:0] old_w,
                               input logic [CFG_DW-1:0] new_w, input logic [CFG_DW-1:0] coeff);
    logic [CFG_DW-1:0] vals [4];
    cfg_idx_t          idx;
    vals[REG_ANGLE_OFFSET] = offset;
    vals[REG_OLD_WEIGHT]   = old_w;
    vals[REG_NEW_WEIGHT]   = new_w;
    vals[REG_RPM_COEFF]    = coeff;
    idx = REG_ANGLE_OFFSET;
    repeat (idx.num()) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= vals[idx];
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // result side: short random stalls, one long hold-off to back up the input
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[encoder_angle_speed_estimator] ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned per_phase;
    per_phase = RANDOM_ITEMS / N_SETTINGS;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: zero count, wrap of the angle sum, negative steps, angle-only repeats
    offer(1'b0, 16'd0);
    offer(1'b1, 16'd0);
    offer(1'b1, 16'd999);
    offer(1'b0, 16'd1000);
    offer(1'b1, 16'd1000);
    offer(1'b1, 16'd1000);
    offer(1'b0, 16'd65535);
    offer(1'b1, 16'd65535);
    offer(1'b1, 16'd65534);
    offer(1'b0, 16'd32768);
    offer(1'b1, 16'd1);
    offer(1'b1, 16'd0);
    settle;

    // sum lands exactly on one turn; full 11-bit weights drive the filter into saturation
    load_settings(16'd33536, 16'd2047, 16'd2047, 16'hFFFF);
    offer(1'b1, 16'd500);
    offer(1'b1, 16'd250);
    offer(1'b1, 16'd0);
    offer(1'b1, 16'd999);
    offer(1'b0, 16'd500);
    offer(1'b1, 16'd750);
    offer(1'b1, 16'd251);
    offer(1'b1, 16'd1500);
    settle;

    for (int s = 0; s < N_SETTINGS; s++) begin
      case (s)
        0: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: load_settings(16'd0, 16'd0, 16'd0, 16'd0);
        2: load_settings(RST_ANGLE_OFFSET, CFG_DW'(RST_OLD_WEIGHT), CFG_DW'(RST_NEW_WEIGHT),
                         RST_RPM_COEFF);
        3: load_settings(16'hFFFF, 16'd1024, 16'd1024, 16'hFFFF);
        4: load_settings(CFG_DW'($urandom_range(0, 65535)), CFG_DW'($urandom_range(0, 1024)),
                         CFG_DW'($urandom_range(0, 1024)), CFG_DW'($urandom_range(0, 65535)));
        default: load_settings(CFG_DW'($urandom), CFG_DW'($urandom), CFG_DW'($urandom),
                               CFG_DW'($urandom));
      endcase
      for (int n = 0; n < per_phase; n++) begin
        if (s == N_SETTINGS - 1 && n == per_phase - CALM_ITEMS)
          calm = 1'b1;
        offer_random;
      end
      settle;
    end

    $display("run covered %0d input transfers (%0d speed updates) under %0d register settings",
             items_sent, speed_items, settings_used);
    $display("%0d results compared field by field, filter saturated on %0d updates",
             results_checked, saturations);
    if (mismatches == 0)
      $display("[encoder_angle_speed_estimator] OK");
    else
      $display("[encoder_angle_speed_estimator] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/eas_pkg.sv
rtl/core/eas_angle.sv
rtl/core/eas_speed.sv
rtl/core/encoder_angle_speed_estimator.sv
tb/angle_speed_checker.sv
tb/tb.sv
